### design/lru_key_value_cache_assert.svh
// Assertion macros for the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LKV_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("cache invariant violated");

// A trigger that must be followed by a condition at the next clock edge.
`define LKV_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("cache sequencing violated");

`endif

### design/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkv_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Result of a get that misses.
  localparam data_t MISS_VALUE = -32'sd1;

  // Controller phases.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lkv_state_t;

  // Control broadcast from the controller to every cell.
  typedef struct packed {
    logic accept;     // capture the match result for the incoming key
    logic update;     // the list changes in this cycle
    logic shift_all;  // insert at the front: every cell takes its neighbor
  } lkv_ctl_t;

endpackage

### design/lkv_cell.sv
// One entry of the recency-ordered list; takes its upstream neighbor on a shift.
module lkv_cell import lkv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  lkv_ctl_t ctl,
  input  data_t    in_key,
  input  logic     prev_valid,
  input  data_t    prev_key,
  input  data_t    prev_value,
  input  logic     kill,
  input  logic     tail_in,
  output logic     entry_valid,
  output data_t    entry_key,
  output data_t    entry_value,
  output logic     hit,
  output logic     tail_out
);

  logic shift_en;

  // A cell at or in front of the hit entry moves back by one; an insert moves all.
  assign tail_out = hit | tail_in;
  assign shift_en = ctl.update & (ctl.shift_all | tail_out);

  // Valid bit and match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
      hit         <= 1'b0;
    end else begin
      if (ctl.accept) begin
        hit <= entry_valid && (entry_key == in_key);
      end
      if (shift_en) begin
        entry_valid <= prev_valid & ~kill;
      end
    end
  end

  // Key and value storage.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_key   <= prev_key;
      entry_value <= prev_value;
    end
  end

endmodule

### design/lru_key_value_cache.sv
// Top level of the LRU key-value cache: controller, cell chain and result register.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------------
//   request | in_valid / in_stall        | cmd, key, value
//   result  | out_valid / out_stall      | found, read_value, evicted
//   config  | cfg_valid / cfg_ready      | cfg_data (capacity)
//
// For each item, the accept edge compares the key in every cell,
// and the update edge moves the list and loads the result register.
// The list is kept in recency order, cell 0 holding the most recent entry.
// Reset empties the list at once and sets the capacity to 16.
// While a result waits under out_stall, the next item is accepted but its
// update holds until the result register frees.
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cmd,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             found,
  output logic signed [DATA_W-1:0] read_value,
  output logic             evicted,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  lkv_state_t     state, state_next;
  lkv_ctl_t       ctl;
  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]  count;
  logic           req_cmd;
  data_t          req_key, req_value;
  logic           upd_go, hit_any, do_evict, is_put;
  logic [CMPW-1:0] cap_eff, count_ext;
  data_t          hit_value, front_value;

  logic [ENTRIES-1:0] valid_vec, hit_vec, kill_vec;
  logic [ENTRIES:0]   tail;
  data_t              key_arr   [ENTRIES];
  data_t              value_arr [ENTRIES];

  // Configuration port is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
      ST_UPDATE: if (!(out_valid && out_stall)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Controller outputs.
  always_comb begin
    in_stall      = (state != ST_IDLE);
    upd_go        = (state == ST_UPDATE) && !(out_valid && out_stall);
    ctl.accept    = in_valid && (state == ST_IDLE);
    ctl.update    = upd_go && (hit_any || is_put);
    ctl.shift_all = is_put && !hit_any;
  end

  // Request holding registers.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      req_cmd   <= cmd;
      req_key   <= key;
      req_value <= value;
    end
  end

  assign is_put  = (req_cmd == CMD_PUT);
  assign hit_any = tail[0];

  // Effective capacity, clamped to one through ENTRIES.
  always_comb begin
    count_ext = CMPW'(count);
    if (capacity == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(capacity) > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end else begin
      cap_eff = CMPW'(capacity);
    end
  end

  assign do_evict = is_put && !hit_any && (count_ext >= cap_eff);

  // Occupied count grows on an insert that evicts nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (upd_go && is_put && !hit_any && !do_evict) begin
      count <= count + CW'(1);
    end
  end

  // Value of the matching cell; at most one cell matches.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (value_arr[i] & {DATA_W{hit_vec[i]}});
    end
  end

  assign front_value = is_put ? req_value : hit_value;
  assign tail[ENTRIES] = 1'b0;

  // The chain of cells, most recent first.
  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    logic  p_valid;
    data_t p_key, p_value;

    if (j == 0) begin : g_front
      assign p_valid = 1'b1;
      assign p_key   = req_key;
      assign p_value = front_value;
    end else begin : g_link
      assign p_valid = valid_vec[j-1];
      assign p_key   = key_arr[j-1];
      assign p_value = value_arr[j-1];
    end

    // The entry pushed to position count on an evicting insert drops out.
    assign kill_vec[j] = do_evict && (count == CW'(j));

    lkv_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .in_key      (key),
      .prev_valid  (p_valid),
      .prev_key    (p_key),
      .prev_value  (p_value),
      .kill        (kill_vec[j]),
      .tail_in     (tail[j+1]),
      .entry_valid (valid_vec[j]),
      .entry_key   (key_arr[j]),
      .entry_value (value_arr[j]),
      .hit         (hit_vec[j]),
      .tail_out    (tail[j])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      found   <= hit_any;
      evicted <= do_evict;
      if (is_put) begin
        read_value <= '0;
      end else if (hit_any) begin
        read_value <= hit_value;
      end else begin
        read_value <= MISS_VALUE;
      end
    end
  end

  // Checks on the list and the controller.
  `LKV_ASSERT_ALWAYS(a_count_range, count_ext <= CMPW'(ENTRIES))
  `LKV_ASSERT_ALWAYS(a_valid_matches_count, $countones(valid_vec) == int'(count))
  `LKV_ASSERT_ALWAYS(a_single_hit, (state != ST_UPDATE) || $onehot0(hit_vec))
  `LKV_ASSERT_NEXT(a_update_done, upd_go, (state == ST_IDLE) && out_valid)
  `LKV_ASSERT_ALWAYS(a_evict_only_miss, !(out_valid && evicted && found))

endmodule
